// ===== hdl/pms_pkg.sv =====
// Shared types and constants of the primer mismatch scan unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package pms_pkg;

   // Field widths
   localparam int PATTERN_W  = 40;
   localparam int LENGTH_W   = 5;
   localparam int MISMATCH_W = 5;
   localparam int BASE_W     = 3;
   localparam int POS_W      = 32;
   localparam int TOTAL_W    = 16;

   // Base codes
   localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;
   localparam logic [1:0]        BASE_C     = 2'd1;
   localparam logic [1:0]        BASE_G     = 2'd2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      REG_PATTERN_BASES  = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_MISMATCH_LIMIT = 2'd2,
      REG_ANCHOR_MODE    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [PATTERN_W-1:0]  pattern_bases;
      logic [LENGTH_W-1:0]   pattern_length;
      logic [MISMATCH_W-1:0] mismatch_limit;
      logic                  anchor_mode;
   } cfg_type;

   // One classified item: which results it causes and their payload
   typedef struct packed {
      logic               sense_hit;
      logic               anti_hit;
      logic               summary;
      logic [POS_W-1:0]   start;
      logic [POS_W-1:0]   next_pos;
      logic [TOTAL_W-1:0] total;
   } entry_type;

endpackage

`default_nettype wire

// ===== hdl/pms_front.sv =====
// Front end: template window, primer preparation, both-strand compare, hit count.
// Depends on pms_pkg; feeds pms_queue.
`default_nettype none

module pms_front #(
   parameter int MAX_PATTERN = 20,
   parameter int ANCHORS     = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pms_pkg::cfg_type            cfg,
   input  logic                        req_push,
   input  logic [pms_pkg::BASE_W-1:0]  req_base,
   input  logic                        req_last,
   output logic                        req_full,
   input  logic [pms_pkg::QCNT_W-1:0]  q_count,
   output logic                        q_push,
   output pms_pkg::entry_type          q_data
);
   import pms_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   // G/C anchor positions in window order (index MAX_PATTERN-1 is the 3' end)
   function automatic logic [MAX_PATTERN-1:0] anchors_of(
      input logic [2*MAX_PATTERN-1:0] exp_bases,
      input logic [MAX_PATTERN-1:0]   act,
      input logic                     mode
   );
      logic [MAX_PATTERN-1:0] gc;
      logic [MAX_PATTERN-1:0] first;
      logic [MAX_PATTERN-1:0] anc;
      logic [MAX_PATTERN-1:0] below;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         gc[i] = act[i] && (exp_bases[2*i +: 2] == BASE_C || exp_bases[2*i +: 2] == BASE_G);
      end
      first = act & ~(act << 1);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         below = (MAX_PATTERN'(1) << i) - MAX_PATTERN'(1);
         if (mode) begin
            anc[i] = gc[i] && ($countones(gc >> (i + 1)) < ANCHORS);
         end else begin
            anc[i] = (gc[i] && !(|(gc & below))) || (first[i] && !(|gc));
         end
      end
      return anc;
   endfunction

   logic                   accept;
   logic [LEN_W-1:0]       len;
   logic [LEN_W-1:0]       sh;

   logic [BASE_W-1:0]      hist_ff [MAX_PATTERN];
   logic [BASE_W-1:0]      hist_in [MAX_PATTERN];
   logic [BASE_W-1:0]      win_ff  [MAX_PATTERN];
   logic [BASE_W-1:0]      win_in  [MAX_PATTERN];
   logic [LEN_W-1:0]       seen_ff, seen_in, seen_next;
   logic [POS_W-1:0]       pos_ff, pos_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_last_ff, s1_last_in;
   logic                   s1_full_ff, s1_full_in;
   logic [POS_W-1:0]       s1_start_ff, s1_start_in;
   logic [POS_W-1:0]       s1_next_ff, s1_next_in;

   logic [63:0]            pat64;
   logic [2*MAX_PATTERN-1:0] pat_pad;
   logic [2*MAX_PATTERN-1:0] exp_s_ff, exp_s_in;
   logic [2*MAX_PATTERN-1:0] exp_r_ff, exp_r_in;
   logic [MAX_PATTERN-1:0] act_ff, act_in;
   logic [MAX_PATTERN-1:0] anc_s_ff, anc_s_in;
   logic [MAX_PATTERN-1:0] anc_r_ff, anc_r_in;

   logic [MAX_PATTERN-1:0] mism_s, mism_r;
   logic                   hit_s, hit_r;
   logic [TOTAL_W:0]       cnt_sum;
   logic [TOTAL_W-1:0]     cnt_sat;
   logic [TOTAL_W-1:0]     cnt_ff, cnt_in;

   // effective pattern length, 1..MAX_PATTERN
   always_comb begin
      if (cfg.pattern_length == '0) begin
         len = LEN_W'(1);
      end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
         len = LEN_W'(MAX_PATTERN);
      end else begin
         len = LEN_W'(cfg.pattern_length);
      end
      sh = LEN_W'(MAX_PATTERN) - len;
   end

   // primer aligned to the window end, refreshed every cycle
   always_comb begin
      pat64 = 64'(cfg.pattern_bases);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_pad[2*i +: 2] = pat64[2*i +: 2];
      end
      exp_s_in = pat_pad << {sh, 1'b0};
      for (int i = 0; i < MAX_PATTERN; i++) begin
         exp_r_in[2*i +: 2] = ~pat_pad[2*(MAX_PATTERN-1-i) +: 2];
         act_in[i]          = (LEN_W'(i) >= sh);
      end
      anc_s_in = anchors_of(exp_s_in, act_in, cfg.anchor_mode);
      anc_r_in = anchors_of(exp_r_in, act_in, cfg.anchor_mode);
   end

   // accept stage
   always_comb begin
      accept = req_push && !req_full;
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
         win_in[i] = hist_ff[i+1];
      end
      win_in[MAX_PATTERN-1] = req_base[2] ? BASE_OTHER : req_base;
      seen_next = (int'(seen_ff) < MAX_PATTERN) ? seen_ff + LEN_W'(1) : seen_ff;

      hist_in = hist_ff;
      seen_in = seen_ff;
      pos_in  = pos_ff;
      if (accept) begin
         if (req_last) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
               hist_in[i] = BASE_OTHER;
            end
            seen_in = '0;
            pos_in  = '0;
         end else begin
            hist_in = win_in;
            seen_in = seen_next;
            pos_in  = pos_ff + POS_W'(1);
         end
      end

      s1_valid_in = accept;
      s1_last_in  = req_last;
      s1_full_in  = (seen_next >= len);
      s1_start_in = pos_ff - POS_W'(len) + POS_W'(1);
      s1_next_in  = pos_ff + POS_W'(1);
   end

   // compare stage
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         mism_s[i] = act_ff[i] && (win_ff[i] != {1'b0, exp_s_ff[2*i +: 2]});
         mism_r[i] = act_ff[i] && (win_ff[i] != {1'b0, exp_r_ff[2*i +: 2]});
      end
      hit_s = s1_full_ff && !(|(anc_s_ff & mism_s))
              && ($countones(mism_s) <= int'(cfg.mismatch_limit));
      hit_r = s1_full_ff && !(|(anc_r_ff & mism_r))
              && ($countones(mism_r) <= int'(cfg.mismatch_limit));

      cnt_sum = {1'b0, cnt_ff} + (TOTAL_W+1)'(hit_s) + (TOTAL_W+1)'(hit_r);
      cnt_sat = cnt_sum[TOTAL_W] ? '1 : cnt_sum[TOTAL_W-1:0];

      cnt_in = cnt_ff;
      if (s1_valid_ff) begin
         cnt_in = s1_last_ff ? '0 : cnt_sat;
      end

      q_push           = s1_valid_ff && (hit_s || hit_r || s1_last_ff);
      q_data.sense_hit = hit_s;
      q_data.anti_hit  = hit_r;
      q_data.summary   = s1_last_ff;
      q_data.start     = s1_start_ff;
      q_data.next_pos  = s1_next_ff;
      q_data.total     = cnt_sat;
   end

   // room for the item in flight plus a new one
   assign req_full = (int'(q_count) + int'(s1_valid_ff)) >= QUEUE_DEPTH;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            hist_ff[i] <= BASE_OTHER;
         end
         seen_ff     <= '0;
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         hist_ff     <= hist_in;
         seen_ff     <= seen_in;
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff      <= win_in;
         s1_last_ff  <= s1_last_in;
         s1_full_ff  <= s1_full_in;
         s1_start_ff <= s1_start_in;
         s1_next_ff  <= s1_next_in;
      end
      exp_s_ff <= exp_s_in;
      exp_r_ff <= exp_r_in;
      act_ff   <= act_in;
      anc_s_ff <= anc_s_in;
      anc_r_ff <= anc_r_in;
   end

endmodule

`default_nettype wire

// ===== hdl/pms_queue.sv =====
// Short queue of classified items between front and back.
// Depends on pms_pkg.
`default_nettype none

module pms_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  pms_pkg::entry_type          push_data,
   input  logic                        pop,
   output pms_pkg::entry_type          head,
   output logic                        empty,
   output logic [pms_pkg::QCNT_W-1:0]  count
);
   import pms_pkg::*;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pms_back.sv =====
// Back end: unpacks one queued item into its sense, antisense and summary results.
// Depends on pms_pkg; drains pms_queue.
`default_nettype none

module pms_back (
   input  logic                         clock,
   input  logic                         reset,
   input  pms_pkg::entry_type           head,
   input  logic                         q_empty,
   output logic                         q_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [pms_pkg::POS_W-1:0]    rsp_position,
   output logic                         rsp_antisense,
   output logic                         rsp_is_summary,
   output logic [pms_pkg::TOTAL_W-1:0]  rsp_hit_total,
   output logic                         rsp_last
);
   import pms_pkg::*;

   // pending result bits, sent lowest first
   localparam int P_SENSE = 0;
   localparam int P_ANTI  = 1;
   localparam int P_SUM   = 2;

   entry_type   ent_ff, ent_in;
   logic [2:0]  pend_ff, pend_in;
   logic [2:0]  rest;
   logic [2:0]  sel;
   logic [2:0]  after_pop;
   logic        taken;

   always_comb begin
      rest      = pend_ff & (pend_ff - 3'd1);
      sel       = pend_ff & ~(pend_ff - 3'd1);
      taken     = rsp_pop && (pend_ff != '0);
      after_pop = taken ? rest : pend_ff;

      q_pop   = (after_pop == '0) && !q_empty;
      pend_in = after_pop;
      ent_in  = ent_ff;
      if (q_pop) begin
         pend_in[P_SENSE] = head.sense_hit;
         pend_in[P_ANTI]  = head.anti_hit;
         pend_in[P_SUM]   = head.summary;
         ent_in           = head;
      end
   end

   always_comb begin
      rsp_empty      = (pend_ff == '0);
      rsp_last       = (rest == '0);
      rsp_antisense  = sel[P_ANTI];
      rsp_is_summary = sel[P_SUM];
      rsp_hit_total  = sel[P_SUM] ? ent_ff.total : '0;
      if (sel[P_SENSE]) begin
         rsp_position = ent_ff.start;
      end else if (sel[P_ANTI]) begin
         rsp_position = ent_ff.next_pos;
      end else begin
         rsp_position = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

`default_nettype wire

// ===== hdl/primer_mismatch_scan_unit.sv =====
// Top level of the primer mismatch scan unit: register port, front, queue, back.
// Depends on pms_pkg, pms_front, pms_queue and pms_back.
//
//   channel   ports         handshake                    moves
//   req       req_*         push & !full                 one template base per item
//   rsp       rsp_*         pop & !empty                 one hit or summary per item
//   csr       csr_*         psel & penable & pwrite      64-bit register write, 8-byte stride
//
// One template base is taken per cycle while the queue has room; the front
// registers the shifted window and compares it on both strands. The back sends
// one result per cycle while the consumer pops; a base with two or three
// results holds the queue until its last result is popped, and req_full rises
// once the four queue entries, counting the item in the compare stage, are
// spoken for. Reset is synchronous, clears the window and counters at once and
// loads the register defaults; there is no clearing pass.
`default_nettype none

module primer_mismatch_scan_unit #(
   parameter int MAX_PATTERN = 20,
   parameter int ANCHORS     = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   // template bases
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [pms_pkg::BASE_W-1:0]      req_base,
   input  logic                            req_last,
   // hits and summaries
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [pms_pkg::POS_W-1:0]       rsp_position,
   output logic                            rsp_antisense,
   output logic                            rsp_is_summary,
   output logic [pms_pkg::TOTAL_W-1:0]     rsp_hit_total,
   output logic                            rsp_last,
   // registers
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pms_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pms_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pms_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import pms_pkg::*;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 5'd12;

   logic [PATTERN_W-1:0]   pattern_ff, pattern_in;
   logic [LENGTH_W-1:0]    length_ff, length_in;
   logic [MISMATCH_W-1:0]  mismatch_ff, mismatch_in;
   logic                   mode_ff, mode_in;
   logic                   csr_wr;
   reg_index_type          csr_idx;

   cfg_type                cfg;
   logic                   q_push;
   entry_type              q_data;
   logic                   q_pop;
   entry_type              q_head;
   logic                   q_empty;
   logic [QCNT_W-1:0]      q_count;

   // register file; low address bits inside a register's slot are ignored
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      pattern_in  = pattern_ff;
      length_in   = length_ff;
      mismatch_in = mismatch_ff;
      mode_in     = mode_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_PATTERN_BASES:  pattern_in  = csr_pwdata[PATTERN_W-1:0];
            REG_PATTERN_LENGTH: length_in   = csr_pwdata[LENGTH_W-1:0];
            REG_MISMATCH_LIMIT: mismatch_in = csr_pwdata[MISMATCH_W-1:0];
            REG_ANCHOR_MODE:    mode_in     = csr_pwdata[0];
            default:            pattern_in  = pattern_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PATTERN_BASES:  csr_prdata = CSR_DATA_W'(pattern_ff);
         REG_PATTERN_LENGTH: csr_prdata = CSR_DATA_W'(length_ff);
         REG_MISMATCH_LIMIT: csr_prdata = CSR_DATA_W'(mismatch_ff);
         REG_ANCHOR_MODE:    csr_prdata = CSR_DATA_W'(mode_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         length_ff   <= LENGTH_RESET;
         mismatch_ff <= '0;
         mode_ff     <= 1'b1;
      end else begin
         pattern_ff  <= pattern_in;
         length_ff   <= length_in;
         mismatch_ff <= mismatch_in;
         mode_ff     <= mode_in;
      end
   end

   always_comb begin
      cfg.pattern_bases  = pattern_ff;
      cfg.pattern_length = length_ff;
      cfg.mismatch_limit = mismatch_ff;
      cfg.anchor_mode    = mode_ff;
   end

   // window, compare and hit count
   pms_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .ANCHORS     (ANCHORS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_push (req_push),
      .req_base (req_base),
      .req_last (req_last),
      .req_full (req_full),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   // only items that cause at least one result are queued
   pms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .count     (q_count)
   );

   // one result per cycle toward the consumer while it pops
   pms_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_position   (rsp_position),
      .rsp_antisense  (rsp_antisense),
      .rsp_is_summary (rsp_is_summary),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== test/tb_primer_mismatch_scan_unit.sv =====
// Self-checking testbench for primer_mismatch_scan_unit: a queue-fed base driver
// that runs a scan predictor, a result monitor, and an APB register writer.
// Depends on pms_pkg and the primer_mismatch_scan_unit RTL.
`timescale 1ns / 100ps

module tb_primer_mismatch_scan_unit;
   import pms_pkg::*;

   localparam int WINDOW = 20;   // MAX_PATTERN of the unit
   localparam int ANCHOR_MAX = 4;
   localparam int SETTLE_CYCLES = 8;   // margin for the compare stage to drain
   localparam int RSP_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              last;
   } base_item_type;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic               antisense;
      logic               is_summary;
      logic [TOTAL_W-1:0] hit_total;
      logic               last;
   } scan_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // block ports
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [BASE_W-1:0]     req_base = '0;
   logic                  req_last = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [POS_W-1:0]      rsp_position;
   logic                  rsp_antisense;
   logic                  rsp_is_summary;
   logic [TOTAL_W-1:0]    rsp_hit_total;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   primer_mismatch_scan_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_base       (req_base),
      .req_last       (req_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_position   (rsp_position),
      .rsp_antisense  (rsp_antisense),
      .rsp_is_summary (rsp_is_summary),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // ---------------------------------------------------------------------
   // Scan predictor: own copy of registers, window and counters
   // ---------------------------------------------------------------------
   logic [PATTERN_W-1:0]  cfg_pattern;
   logic [LENGTH_W-1:0]   cfg_len;
   logic [MISMATCH_W-1:0] cfg_mm;
   logic                  cfg_anchor;

   logic [BASE_W-1:0] win_m [0:WINDOW-1];
   int unsigned       seen_m;
   logic [POS_W-1:0]  pos_m;
   int unsigned       hits_m;

   base_item_type   template_q[$];     // bases waiting for the driver
   scan_result_type predicted_q[$];    // hits and summaries not yet seen at rsp
   int              fail_count = 0;

   function automatic int eff_len();
      if (cfg_len == 0) return 1;
      if (cfg_len > WINDOW) return WINDOW;
      return int'(cfg_len);
   endfunction

   function automatic logic [1:0] primer_at(int i);
      return cfg_pattern[2*i +: 2];
   endfunction

   function automatic bit is_gc(logic [1:0] b);
      return (b == BASE_C) || (b == BASE_G);
   endfunction

   task automatic clear_scan_state();
      int i;
      for (i = 0; i < WINDOW; i++) win_m[i] = BASE_OTHER;
      seen_m = 0;
      pos_m  = '0;
      hits_m = 0;
   endtask

   // Compare the newest len window bases against one strand of the primer.
   function automatic bit strand_match(int len, bit rc);
      logic [1:0] pat [0:WINDOW-1];
      int anch [0:ANCHOR_MAX-1];
      int nanch;
      int mism;
      int off;
      int j;
      int k;
      off   = WINDOW - len;
      nanch = 0;
      mism  = 0;
      for (j = 0; j < len; j++)
         pat[j] = rc ? 2'd3 - primer_at(len - 1 - j) : primer_at(j);
      if (cfg_anchor) begin
         // up to four G/C positions counted from the 3' end
         for (k = len; k > 0 && nanch < ANCHOR_MAX; k--)
            if (is_gc(pat[k-1])) begin
               anch[nanch] = k - 1;
               nanch++;
            end
      end else begin
         // first G/C from the 5' end, position 0 when there is none
         anch[0] = 0;
         nanch   = 1;
         for (j = len - 1; j >= 0; j--)
            if (is_gc(pat[j])) anch[0] = j;
      end
      for (k = 0; k < nanch; k++)
         if (win_m[off + anch[k]] != {1'b0, pat[anch[k]]}) return 1'b0;
      for (j = 0; j < len; j++)
         if (win_m[off + j] != {1'b0, pat[j]}) mism++;
      return mism <= int'(cfg_mm);
   endfunction

   task automatic bump_hits();
      if (hits_m < 16'hFFFF) hits_m++;
   endtask

   // Advance the predictor by one accepted base and queue what it causes.
   task automatic scan_base(logic [BASE_W-1:0] b, logic lst);
      scan_result_type res [0:2];
      int n;
      int len;
      int i;
      logic [POS_W-1:0] start;
      n   = 0;
      len = eff_len();
      for (i = 0; i < WINDOW - 1; i++) win_m[i] = win_m[i+1];
      win_m[WINDOW-1] = (b > 3) ? BASE_OTHER : b;
      if (seen_m < WINDOW) seen_m++;
      start = pos_m - POS_W'(len) + 32'd1;
      pos_m = pos_m + 32'd1;
      if (seen_m >= len) begin
         if (strand_match(len, 1'b0)) begin
            res[n] = '{position: start, antisense: 1'b0, is_summary: 1'b0,
                       hit_total: '0, last: 1'b0};
            n++;
            bump_hits();
         end
         if (strand_match(len, 1'b1)) begin
            res[n] = '{position: start + POS_W'(len), antisense: 1'b1,
                       is_summary: 1'b0, hit_total: '0, last: 1'b0};
            n++;
            bump_hits();
         end
      end
      if (lst) begin
         res[n] = '{position: '0, antisense: 1'b0, is_summary: 1'b1,
                    hit_total: TOTAL_W'(hits_m), last: 1'b0};
         n++;
         clear_scan_state();
      end
      for (i = 0; i < n; i++) begin
         res[i].last = (i == n - 1);
         predicted_q.push_back(res[i]);
      end
   endtask

   // ---------------------------------------------------------------------
   // Base driver: feeds template_q into req_*, with random gap bursts
   // ---------------------------------------------------------------------
   bit            sender_gaps_on = 1'b1;
   int            req_gap_left = 0;
   base_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) scan_base(req_base, req_last);
         if (req_push && req_full) begin
            // stalled: keep offering the same item
         end else if (req_gap_left > 0) begin
            req_gap_left--;
            req_push <= 1'b0;
         end else if (template_q.size() > 0 && sender_gaps_on
                      && $urandom_range(0, 7) == 0) begin
            req_gap_left = $urandom_range(0, 15);
            req_push <= 1'b0;
         end else if (template_q.size() > 0) begin
            next_item = template_q.pop_front();
            req_base <= next_item.base;
            req_last <= next_item.last;
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: pops rsp_*, compares with the oldest prediction
   // ---------------------------------------------------------------------
   bit              receiver_gaps_on = 1'b1;
   int              rsp_gap_left = 0;
   bit              rsp_hold = 1'b0;   // long hold-off, timed by its own process
   scan_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (predicted_q.size() == 0) begin
               $error("unexpected result: position %0d antisense %0b summary %0b",
                      rsp_position, rsp_antisense, rsp_is_summary);
               fail_count++;
            end else begin
               want = predicted_q.pop_front();
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, actual %0d", want.position, rsp_position);
                  fail_count++;
               end
               if (rsp_antisense !== want.antisense) begin
                  $error("antisense: expected %0b, actual %0b", want.antisense, rsp_antisense);
                  fail_count++;
               end
               if (rsp_is_summary !== want.is_summary) begin
                  $error("is_summary: expected %0b, actual %0b",
                         want.is_summary, rsp_is_summary);
                  fail_count++;
               end
               if (rsp_hit_total !== want.hit_total) begin
                  $error("hit_total: expected %0d, actual %0d", want.hit_total, rsp_hit_total);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (rsp_hold) begin
            rsp_pop <= 1'b0;
         end else if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_pop <= 1'b0;
         end else if (receiver_gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_gap_left = $urandom_range(0, 15);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer helpers
   // ---------------------------------------------------------------------

   // APB write: setup, access, done at the edge that sees pready
   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_PATTERN_BASES:  cfg_pattern = value[PATTERN_W-1:0];
         REG_PATTERN_LENGTH: cfg_len     = value[LENGTH_W-1:0];
         REG_MISMATCH_LIMIT: cfg_mm      = value[MISMATCH_W-1:0];
         REG_ANCHOR_MODE:    cfg_anchor  = value[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Wait until every base is taken and every result seen, then let the
   // compare stage drain bases that produce nothing.
   task automatic settle();
      @(posedge clock);
      while (template_q.size() != 0 || req_push || predicted_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(logic [PATTERN_W-1:0] pat, logic [LENGTH_W-1:0] len,
                              logic [MISMATCH_W-1:0] mm, logic anch);
      settle();
      write_reg(REG_PATTERN_BASES, CSR_DATA_W'(pat));
      write_reg(REG_PATTERN_LENGTH, CSR_DATA_W'(len));
      write_reg(REG_MISMATCH_LIMIT, CSR_DATA_W'(mm));
      write_reg(REG_ANCHOR_MODE, CSR_DATA_W'(anch));
   endtask

   // shared flags change away from the rising edge
   task automatic set_gaps(bit snd, bit rcv);
      @(negedge clock);
      sender_gaps_on   = snd;
      receiver_gaps_on = rcv;
   endtask

   task automatic queue_base(logic [BASE_W-1:0] b, logic lst);
      template_q.push_back(base_item_type'({b, lst}));
   endtask

   function automatic logic [BASE_W-1:0] rand_base();
      if ($urandom_range(0, 9) < 8) return BASE_W'($urandom_range(0, 3));
      return BASE_W'($urandom_range(4, 7));
   endfunction

   function automatic logic [PATTERN_W-1:0] rand_pattern();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[PATTERN_W-1:0];
   endfunction

   // Mostly templates with a planted primer copy (either strand, up to three bases
   // mutated); the rest is short noise. The final base may or may not end it.
   task automatic queue_random(int count);
      logic [BASE_W-1:0] seq[$];
      int goal;
      int len;
      int n;
      int j;
      bit rc;
      goal = template_q.size() + count;
      while (template_q.size() < goal) begin
         seq.delete();
         len = eff_len();
         if ($urandom_range(0, 3) != 0) begin
            n = $urandom_range(0, 4);
            repeat (n) seq.push_back(rand_base());
            rc = $urandom_range(0, 1);
            for (j = 0; j < len; j++)
               seq.push_back({1'b0, rc ? 2'd3 - primer_at(len - 1 - j) : primer_at(j)});
            n = $urandom_range(0, 3);
            repeat (n) seq[$urandom_range(seq.size() - len, seq.size() - 1)] = rand_base();
            n = $urandom_range(0, 3);
            repeat (n) seq.push_back(rand_base());
         end else begin
            n = $urandom_range(1, 8);
            repeat (n) seq.push_back(BASE_W'($urandom_range(0, 7)));
         end
         for (j = 0; j < seq.size(); j++)
            queue_base(seq[j], (j == seq.size() - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      cfg_pattern = '0;
      cfg_len     = 5'd12;
      cfg_mm      = '0;
      cfg_anchor  = 1'b1;
      clear_scan_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Register defaults; a template shorter than the primer, with an other symbol
      queue_base(3'd0, 1'b0);
      queue_base(3'd7, 1'b0);
      queue_base(3'd4, 1'b1);

      // ACGT is its own reverse complement: both strands hit the same window
      load_config(40'hE4, 5'd4, 5'd0, 1'b0);
      queue_base(3'd0, 1'b0);
      queue_base(3'd1, 1'b0);
      queue_base(3'd2, 1'b0);
      queue_base(3'd3, 1'b0);
      queue_base(3'd5, 1'b0);
      queue_base(3'd6, 1'b0);
      queue_base(3'd1, 1'b0);
      queue_base(3'd0, 1'b0);
      queue_base(3'd2, 1'b0);
      queue_base(3'd3, 1'b1);

      // Length zero reads as one base: G hits sense, C hits antisense
      load_config(40'h2, 5'd0, 5'd0, 1'b1);
      queue_base(3'd2, 1'b0);
      queue_base(3'd1, 1'b0);
      queue_base(3'd3, 1'b0);
      queue_base(3'd1, 1'b1);

      // Four 3' anchors on GGCCAA; one mismatch off the anchors still hits
      load_config(40'h5A, 5'd6, 5'd2, 1'b1);
      queue_base(3'd2, 1'b0);
      queue_base(3'd2, 1'b0);
      queue_base(3'd1, 1'b0);
      queue_base(3'd1, 1'b0);
      queue_base(3'd0, 1'b0);
      queue_base(3'd3, 1'b1);

      // Random phases with idling on both sides
      load_config(rand_pattern(), 5'd8, 5'd2, 1'b1);
      queue_random(20);

      // length saturates at the window size, any mismatch count accepted
      load_config({PATTERN_W{1'b1}}, 5'd31, 5'd31, 1'b0);
      queue_random(20);

      // Pressure: one-base primer A, many bases cause a result; the
      // receiver holds off while the sender keeps pushing until req_full rises
      load_config('0, 5'd1, 5'd0, 1'b1);
      set_gaps(1'b0, 1'b1);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      queue_random(20);

      load_config(rand_pattern(), 5'($urandom_range(1, WINDOW)), 5'd0, 1'b0);
      set_gaps(1'b1, 1'b1);
      queue_random(20);

      load_config(rand_pattern(), 5'd0, 5'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      queue_random(12);

      // Last part without idling
      set_gaps(1'b0, 1'b0);
      load_config(rand_pattern(), 5'($urandom_range(1, 12)), 5'($urandom_range(0, 5)),
                  1'($urandom_range(0, 1)));
      queue_random(20);

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("primer_mismatch_scan_unit test passed");
      else
         $display("primer_mismatch_scan_unit test failed");
      $finish;
   end

   // Watchdog: stops a run that hangs and reports a failure
   initial begin
      #5000000;
      $display("primer_mismatch_scan_unit test failed");
      $finish;
   end

endmodule
